// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define GB_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock and off during reset.
`define GB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/gb5_pkg.sv
// Shared constants, types and helper functions of the 5x5 RGB blur core.
package gb5_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int KSIDE          = 5;
	localparam int COEF_FRAC_BITS = 16;
	localparam int CH_W           = 8;
	localparam int NUM_CH         = 3;
	localparam int PIX_W          = NUM_CH * CH_W;
	localparam int COEF_W         = 16;
	localparam int NUM_GROUPS     = 6;
	localparam int GRP_W          = 11;
	localparam int PROD_W         = GRP_W + COEF_W;
	localparam int ACC_W          = PROD_W + 3;
	localparam int ROW_W          = 16;
	localparam int WREG_W         = 13;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int RES_W          = 3;

	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic [CH_W-1:0]  CH_MAX     = '1;

	localparam logic [WREG_W-1:0] WIDTH_RST  = 13'd2048;
	localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'd2048;
	localparam logic [COEF_W-1:0] COEF_RST [NUM_GROUPS] = '{
		16'd10624, 16'd6444, 16'd3908, 16'd1438, 16'd872, 16'd195
	};

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COEF_CENTER  = 3'd2,
		REG_COEF_DIST1   = 3'd3,
		REG_COEF_DIST2   = 3'd4,
		REG_COEF_DIST4   = 3'd5,
		REG_COEF_DIST5   = 3'd6,
		REG_COEF_DIST8   = 3'd7
	} cfg_reg_t;

	// Weight group of a kernel tap, chosen by its squared distance from the center.
	function automatic logic [2:0] tap_group(input int ky, input int kx);
		int d2;
		d2 = (ky - KSIDE / 2) * (ky - KSIDE / 2) + (kx - KSIDE / 2) * (kx - KSIDE / 2);
		unique case (d2)
			0:       return 3'd0;
			1:       return 3'd1;
			2:       return 3'd2;
			4:       return 3'd3;
			5:       return 3'd4;
			default: return 3'd5;
		endcase
	endfunction

endpackage

// File: hw/rtl/gaussian_blur_5x5_rgb_core.sv
// A result of a completed window passes the bank read, tap, group-sum, product and output registers.
// Throughput: one pixel per clock in all rows but the last, unless output stalls; a row
// end gives up to 3 results, a pixel of the last row up to 3 and its end up to 9, one per
// clock, as each reads every line buffer bank once; input waits until the last is issued.
// Reset (arst_n low) clears the position counters, the pipeline valids and the config
// registers to their defaults; the line buffer is not cleared and needs no sweep.
module gaussian_blur_5x5_rgb_core
	import gb5_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [PIX_W-1:0]     s_axis_tdata,   // red_in, green_in, blue_in
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [PIX_W-1:0]     m_axis_tdata,   // red_out, green_out, blue_out
	output logic                 m_axis_tlast,   // last_of_run
	output logic                 m_axis_tuser,   // end_of_frame
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int WX = WW + 1;
	localparam int DQ = (MAX_WIDTH + KSIDE - 1) / KSIDE;
	localparam int AW = (DQ > 1) ? $clog2(DQ) : 1;

	typedef struct packed {
		logic [KSIDE-1:0][RES_W-1:0] rslot;
		logic [KSIDE-1:0][RES_W-1:0] cres;
		logic                        left0;
		logic                        left1;
		logic                        right3;
		logic                        right4;
		logic                        top0;
		logic                        top1;
		logic                        bot3;
		logic                        bot4;
		logic                        last;
		logic                        eof;
	} tapsel_t;

	function automatic logic [RES_W-1:0] res_inc(input logic [RES_W-1:0] r);
		return (r == 3'd4) ? 3'd0 : r + 3'd1;
	endfunction

	function automatic logic [RES_W-1:0] res_sub2(input logic [RES_W-1:0] r);
		return (r >= 3'd2) ? r - 3'd2 : r + 3'd3;
	endfunction

	// Configuration registers
	logic [WREG_W-1:0] width_q;
	logic [ROW_W-1:0]  height_q;
	logic [COEF_W-1:0] coef_q [NUM_GROUPS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				coef_q[g] <= COEF_RST[g];
			end
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q   <= cfg_data[WREG_W-1:0];
				REG_IMAGE_HEIGHT: height_q  <= cfg_data;
				REG_COEF_CENTER:  coef_q[0] <= cfg_data;
				REG_COEF_DIST1:   coef_q[1] <= cfg_data;
				REG_COEF_DIST2:   coef_q[2] <= cfg_data;
				REG_COEF_DIST4:   coef_q[3] <= cfg_data;
				REG_COEF_DIST5:   coef_q[4] <= cfg_data;
				REG_COEF_DIST8:   coef_q[5] <= cfg_data;
				default:          width_q   <= width_q;
			endcase
		end
	end

	logic [WW-1:0]    w_eff;
	logic [ROW_W-1:0] h_eff;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff = (height_q == '0) ? ROW_W'(1) : height_q;
	end

	// Position of the next input pixel; column kept also as quotient and residue by 5.
	logic [CW-1:0]    col_q;
	logic [AW-1:0]    colq_q;
	logic [RES_W-1:0] colr_q;
	logic [ROW_W-1:0] row_q;
	logic [RES_W-1:0] rowm_q;

	// Pending output job of the last accepted pixel
	logic             job_valid_q;
	logic [ROW_W-1:0] jr_q, jr1_q;
	logic [RES_W-1:0] jrm_q;
	logic [CW-1:0]    jc_q, jc0_q, jc1_q;
	logic [AW-1:0]    jcq_q, jc0q_q;
	logic [RES_W-1:0] jcr_q, jc0r_q;

	logic adv, issue, row_end, job_end, accept;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign issue         = job_valid_q && adv;
	assign row_end       = (jc_q == jc1_q);
	assign job_end       = row_end && (jr_q == jr1_q);
	// The last read of a job and the write of the next pixel share an edge: reads see old data.
	assign s_axis_tready = !job_valid_q || (adv && job_end);
	assign accept        = s_axis_tvalid && s_axis_tready;

	logic [CW-1:0]    x;
	logic [AW-1:0]    xq;
	logic [RES_W-1:0] xr;
	logic [ROW_W-1:0] y;
	logic [RES_W-1:0] ym;
	logic [CW-1:0]    col_d;
	logic [AW-1:0]    colq_d;
	logic [RES_W-1:0] colr_d;
	logic [ROW_W-1:0] row_d;
	logic [RES_W-1:0] rowm_d;
	logic             last_row, last_col, yge2, xge2, job_new;
	logic [ROW_W-1:0] r0_d, r1_d;
	logic [RES_W-1:0] r0m_d;
	logic [CW-1:0]    c0_d, c1_d;
	logic [AW-1:0]    c0q_d;
	logic [RES_W-1:0] c0r_d;

	always_comb begin
		x  = col_q;
		xq = colq_q;
		xr = colr_q;
		y  = row_q;
		ym = rowm_q;
		// After a size change the position may lie outside the frame.
		if (WW'(col_q) >= w_eff) begin
			x  = '0;
			xq = '0;
			xr = '0;
			y  = row_q + 1'b1;
			ym = res_inc(rowm_q);
		end
		if (y >= h_eff) begin
			y  = '0;
			ym = '0;
		end

		last_col = (WX'(x) + WX'(1)) >= WX'(w_eff);
		last_row = ((ROW_W + 1)'(y) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(h_eff);
		if (last_col) begin
			col_d  = '0;
			colq_d = '0;
			colr_d = '0;
			if (last_row) begin
				row_d  = '0;
				rowm_d = '0;
			end else begin
				row_d  = y + 1'b1;
				rowm_d = res_inc(ym);
			end
		end else begin
			col_d  = x + 1'b1;
			colr_d = res_inc(xr);
			colq_d = (xr == 3'd4) ? xq + 1'b1 : xq;
			row_d  = y;
			rowm_d = ym;
		end

		yge2  = (y >= ROW_W'(2));
		xge2  = (x >= CW'(2));
		r0_d  = yge2 ? y - ROW_W'(2) : '0;
		r0m_d = yge2 ? res_sub2(ym) : '0;
		r1_d  = last_row ? y : y - ROW_W'(2);
		c0_d  = xge2 ? x - CW'(2) : '0;
		c0r_d = xge2 ? res_sub2(xr) : '0;
		c0q_d = (xge2 && xr >= 3'd2) ? xq : (xge2 ? xq - 1'b1 : '0);
		c1_d  = last_col ? x : x - CW'(2);
		job_new = (last_row || yge2) && (last_col || xge2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			colq_q      <= '0;
			colr_q      <= '0;
			row_q       <= '0;
			rowm_q      <= '0;
			job_valid_q <= 1'b0;
			jr_q        <= '0;
			jrm_q       <= '0;
			jr1_q       <= '0;
			jc_q        <= '0;
			jcq_q       <= '0;
			jcr_q       <= '0;
			jc0_q       <= '0;
			jc0q_q      <= '0;
			jc0r_q      <= '0;
			jc1_q       <= '0;
		end else begin
			if (accept) begin
				col_q       <= col_d;
				colq_q      <= colq_d;
				colr_q      <= colr_d;
				row_q       <= row_d;
				rowm_q      <= rowm_d;
				job_valid_q <= job_new;
				jr_q        <= r0_d;
				jrm_q       <= r0m_d;
				jr1_q       <= r1_d;
				jc_q        <= c0_d;
				jcq_q       <= c0q_d;
				jcr_q       <= c0r_d;
				jc0_q       <= c0_d;
				jc0q_q      <= c0q_d;
				jc0r_q      <= c0r_d;
				jc1_q       <= c1_d;
			end else if (issue) begin
				if (job_end) begin
					job_valid_q <= 1'b0;
				end else if (row_end) begin
					jc_q  <= jc0_q;
					jcq_q <= jc0q_q;
					jcr_q <= jc0r_q;
					jr_q  <= jr_q + 1'b1;
					jrm_q <= res_inc(jrm_q);
				end else begin
					jc_q  <= jc_q + 1'b1;
					jcr_q <= res_inc(jcr_q);
					jcq_q <= (jcr_q == 3'd4) ? jcq_q + 1'b1 : jcq_q;
				end
			end
		end
	end

	// Read addresses and tap selection for the output pixel being issued
	logic [AW-1:0]    tq    [KSIDE];
	logic [RES_W-1:0] tr    [KSIDE];
	logic [AW-1:0]    baddr [KSIDE];
	tapsel_t          sel_d;

	always_comb begin
		logic [3:0] s;
		s     = '0;
		sel_d = '0;
		for (int k = 0; k < KSIDE; k++) begin
			s = 4'(jcr_q) + 4'(k) + 4'd3;
			if (s >= 4'd10) begin
				tr[k] = 3'(s - 4'd10);
				tq[k] = jcq_q + 1'b1;
			end else if (s >= 4'd5) begin
				tr[k] = 3'(s - 4'd5);
				tq[k] = jcq_q;
			end else begin
				tr[k] = 3'(s);
				tq[k] = jcq_q - 1'b1;
			end
			sel_d.cres[k] = tr[k];
			s = 4'(jrm_q) + 4'(k) + 4'd3;
			if (s >= 4'd10) begin
				sel_d.rslot[k] = 3'(s - 4'd10);
			end else if (s >= 4'd5) begin
				sel_d.rslot[k] = 3'(s - 4'd5);
			end else begin
				sel_d.rslot[k] = 3'(s);
			end
		end
		for (int j = 0; j < KSIDE; j++) begin
			baddr[j] = '0;
			for (int k = 0; k < KSIDE; k++) begin
				if (tr[k] == 3'(j)) begin
					baddr[j] = tq[k];
				end
			end
		end
		sel_d.left0  = (jc_q < CW'(2));
		sel_d.left1  = (jc_q == '0);
		sel_d.right3 = (WX'(jc_q) + WX'(1)) >= WX'(w_eff);
		sel_d.right4 = (WX'(jc_q) + WX'(2)) >= WX'(w_eff);
		sel_d.top0   = (jr_q < ROW_W'(2));
		sel_d.top1   = (jr_q == '0);
		sel_d.bot3   = ((ROW_W + 2)'(jr_q) + (ROW_W + 2)'(1)) >= (ROW_W + 2)'(h_eff);
		sel_d.bot4   = ((ROW_W + 2)'(jr_q) + (ROW_W + 2)'(2)) >= (ROW_W + 2)'(h_eff);
		sel_d.last   = job_end;
		sel_d.eof    = (jr_q == h_eff - 1'b1) && (WW'(jc_q) == w_eff - 1'b1);
	end

	// Line buffer: one bank per row slot (row mod 5) and column residue (column mod 5).
	pixel_t bank_rd [KSIDE][KSIDE];

	for (genvar gi = 0; gi < KSIDE; gi++) begin : g_slot
		for (genvar gj = 0; gj < KSIDE; gj++) begin : g_res
			pixel_t mem [DQ];
			pixel_t rdat_s1;

			always_ff @(posedge clk) begin
				if (adv) begin
					rdat_s1 <= mem[baddr[gj]];
				end
				if (accept && ym == 3'(gi) && xr == 3'(gj)) begin
					mem[xq] <= s_axis_tdata;
				end
			end

			assign bank_rd[gi][gj] = rdat_s1;
		end
	end

	// Pipeline
	logic    v_s1, v_s2, v_s3, v_s4;
	tapsel_t sel_s1;
	pixel_t  rowd [KSIDE][KSIDE];
	pixel_t  tap [KSIDE][KSIDE];
	pixel_t  win_s2 [KSIDE][KSIDE];
	logic    last_s2, last_s3, last_s4;
	logic    eof_s2, eof_s3, eof_s4;
	logic [GRP_W-1:0]  grp    [NUM_CH][NUM_GROUPS];
	logic [GRP_W-1:0]  grp_s3 [NUM_CH][NUM_GROUPS];
	logic [PROD_W-1:0] prod_s4 [NUM_CH][NUM_GROUPS];
	logic [PIX_W-1:0]  res_d;

	always_comb begin
		for (int ky = 0; ky < KSIDE; ky++) begin
			for (int j = 0; j < KSIDE; j++) begin
				rowd[ky][j] = bank_rd[sel_s1.rslot[ky]][j];
			end
			for (int k = 0; k < KSIDE; k++) begin
				tap[ky][k] = rowd[ky][sel_s1.cres[k]];
			end
			// Taps beyond the left or right edge repeat the edge column.
			if (sel_s1.left1) begin
				tap[ky][1] = tap[ky][2];
			end
			if (sel_s1.left0) begin
				tap[ky][0] = tap[ky][1];
			end
			if (sel_s1.right3) begin
				tap[ky][3] = tap[ky][2];
			end
			if (sel_s1.right4) begin
				tap[ky][4] = tap[ky][3];
			end
		end
		for (int k = 0; k < KSIDE; k++) begin
			if (sel_s1.top1) begin
				tap[1][k] = tap[2][k];
			end
			if (sel_s1.top0) begin
				tap[0][k] = tap[1][k];
			end
			if (sel_s1.bot3) begin
				tap[3][k] = tap[2][k];
			end
			if (sel_s1.bot4) begin
				tap[4][k] = tap[3][k];
			end
		end
	end

	// Taps that share a weight are summed first, so each channel needs six products.
	always_comb begin
		logic [2:0] g;
		g = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int gi = 0; gi < NUM_GROUPS; gi++) begin
				grp[ch][gi] = '0;
			end
		end
		for (int ky = 0; ky < KSIDE; ky++) begin
			for (int k = 0; k < KSIDE; k++) begin
				g = tap_group(ky, k);
				for (int ch = 0; ch < NUM_CH; ch++) begin
					grp[ch][g] = grp[ch][g] + GRP_W'(win_s2[ky][k][ch*CH_W +: CH_W]);
				end
			end
		end
	end

	always_comb begin
		logic [ACC_W-1:0] acc;
		logic [ACC_W-1:0] rnd;
		acc = '0;
		rnd = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			acc = ROUND_HALF;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				acc = acc + ACC_W'(prod_s4[ch][g]);
			end
			rnd = acc >> COEF_FRAC_BITS;
			res_d[ch*CH_W +: CH_W] = (rnd > ACC_W'(CH_MAX)) ? CH_MAX : rnd[CH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1          <= job_valid_q;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			v_s4          <= v_s3;
			m_axis_tvalid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s1  <= sel_d;
			win_s2  <= tap;
			last_s2 <= sel_s1.last;
			eof_s2  <= sel_s1.eof;
			grp_s3  <= grp;
			last_s3 <= last_s2;
			eof_s3  <= eof_s2;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				for (int g = 0; g < NUM_GROUPS; g++) begin
					prod_s4[ch][g] <= PROD_W'(grp_s3[ch][g]) * PROD_W'(coef_q[g]);
				end
			end
			last_s4      <= last_s3;
			eof_s4       <= eof_s3;
			m_axis_tdata <= res_d;
			m_axis_tlast <= last_s4;
			m_axis_tuser <= eof_s4;
		end
	end

endmodule

// File: hw/rtl/gb5_checker.sv
// Port-level checks of the blur core and the bind that attaches them.
`include "assert_macros.svh"

module gb5_checker
	import gb5_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [PIX_W-1:0] m_axis_tdata,   // red_out, green_out, blue_out
	input logic             m_axis_tlast,   // last_of_run
	input logic             m_axis_tuser,   // end_of_frame
	input logic             cfg_ready
);

	// A stalled result beat keeps its payload.
	`GB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output beat changed")

	// The bottom-right pixel is always the final result of its input pixel.
	`GB_ASSERT_IMPLIES(a_eof_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "end of frame without tlast")

	// Once the core is ready for a pixel it stays ready until one arrives.
	`GB_ASSERT_NEXT(a_ready_keeps, s_axis_tready && !s_axis_tvalid, s_axis_tready, "input ready dropped without a beat")

	`GB_ASSERT_IMPLIES(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")

endmodule

bind gaussian_blur_5x5_rgb_core gb5_checker u_gb5_checker (.*);
